>>> design/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants for the PWM pulse capture block
// Field widths, function codes, register indexes and the result word layout.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int unsigned ChanW  = 3;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Function codes of an input word
  localparam logic FuncCapture = 1'b0;
  localparam logic FuncRead    = 1'b1;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegPeriodTop   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRisingSplit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWrapLimit   = 2'd2;

  // Register reset values
  localparam logic [TimeW-1:0] PeriodTopRst   = 16'd2499;
  localparam logic [TimeW-1:0] RisingSplitRst = 16'd1499;
  localparam logic [TimeW-1:0] WrapLimitRst   = 16'd1000;

  typedef struct packed {
    logic             func;
    logic [ChanW-1:0] channel;
    logic [TimeW-1:0] capture_value;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0] out_channel;
    logic [TimeW-1:0] pulse_width;
    logic             next_edge_rising;
    logic             width_updated;
  } res_t;

  typedef struct packed {
    logic [TimeW-1:0] period_top;
    logic [TimeW-1:0] rising_split;
    logic [TimeW-1:0] wrap_falling_limit;
  } cfg_t;

endpackage

>>> design/mpc_if.sv
// ----------------------------------------------------------------------------
// mpc_if: stream interfaces of the PWM pulse capture block
// Capture/read word channel, result word channel and register write channel.
// ----------------------------------------------------------------------------
interface mpc_in_if;
  import mpc_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [ChanW-1:0] channel;
  logic [TimeW-1:0] capture_value;

  modport source (output valid, func, channel, capture_value, input ready);
  modport sink   (input valid, func, channel, capture_value, output ready);
endinterface

interface mpc_out_if;
  import mpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_channel;
  logic [TimeW-1:0] pulse_width;
  logic             next_edge_rising;
  logic             width_updated;

  modport source (output valid, out_channel, pulse_width, next_edge_rising, width_updated,
                  input ready);
  modport sink   (input valid, out_channel, pulse_width, next_edge_rising, width_updated,
                  output ready);
endinterface

interface mpc_cfg_if;
  import mpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/multichannel_pwm_pulse_capture.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_pulse_capture: PWM input pulse width capture
// Turns timer capture values into per-channel pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one word per capture event (func = capture) or width read
//         (func = read), with channel index and timer capture value.
//   out_o returns one word per input word: channel, stored width, next
//         expected edge and whether this word wrote a new width.
//   cfg_i writes period_top (0), rising_split (1), wrap_falling_limit (2);
//         other indexes are dropped. Write only while the block is idle.
// Timing:
//   A word passes an input register, then the channel bank logic into the
//   result register, which drives out_o. Throughput is one word per cycle
//   while out_o is ready; consecutive words on the same channel see each
//   other's state updates since the bank is written when a word leaves the
//   input register.
// Reset: every channel expects a rising edge, rise times and widths are zero,
//   registers take 2499 / 1499 / 1000.
// Stall: when out_o is not ready the result register holds, the input
//   register holds behind it, and in_i drops ready once both are full.
// ----------------------------------------------------------------------------
module multichannel_pwm_pulse_capture #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpc_in_if.sink    in_i,
  mpc_out_if.source out_o,
  mpc_cfg_if.sink   cfg_i
);
  import mpc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_q;
  logic cmd_vld_q;
  res_t res_q;
  logic res_vld_q;
  res_t res_d;
  logic adv;
  logic fire;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_top         <= PeriodTopRst;
      cfg_q.rising_split       <= RisingSplitRst;
      cfg_q.wrap_falling_limit <= WrapLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegPeriodTop:   cfg_q.period_top         <= cfg_i.data;
        RegRisingSplit: cfg_q.rising_split       <= cfg_i.data;
        RegWrapLimit:   cfg_q.wrap_falling_limit <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Advance the pipe when the result register is free or being taken
  assign adv        = !res_vld_q || out_o.ready;
  assign fire       = cmd_vld_q && adv;
  assign in_i.ready = !cmd_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      cmd_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q.func          <= in_i.func;
      cmd_q.channel       <= in_i.channel;
      cmd_q.capture_value <= in_i.capture_value;
    end
  end

  mpc_channel_bank #(
    .CHANNELS(CHANNELS)
  ) u_bank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .cmd_i (cmd_q),
    .cfg_i (cfg_q),
    .res_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= cmd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = res_vld_q;
  assign out_o.out_channel      = res_q.out_channel;
  assign out_o.pulse_width      = res_q.pulse_width;
  assign out_o.next_edge_rising = res_q.next_edge_rising;
  assign out_o.width_updated    = res_q.width_updated;

endmodule

>>> design/mpc_channel_bank.sv
// ----------------------------------------------------------------------------
// mpc_channel_bank: per-channel edge state and pulse width store
// Holds expected edge, rise time and width per channel; computes one result.
// ----------------------------------------------------------------------------
module mpc_channel_bank #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  mpc_pkg::cmd_t  cmd_i,
  input  mpc_pkg::cfg_t  cfg_i,
  output mpc_pkg::res_t  res_o
);
  import mpc_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] expect_rising_q;
  logic [TimeW-1:0]    rise_time_q   [CHANNELS];
  logic [TimeW-1:0]    width_store_q [CHANNELS];

  logic             in_range;
  logic [IdxW-1:0]  idx;
  logic             exp_r;
  logic [TimeW-1:0] rise_r;
  logic [TimeW-1:0] width_r;
  logic             is_cap;
  logic             take_rise;
  logic             normal_ok;
  logic             wrap_ok;
  logic             updated;
  logic [TimeW-1:0] new_width;

  assign in_range = 32'(cmd_i.channel) < CHANNELS;
  assign idx      = IdxW'(cmd_i.channel);
  assign exp_r    = expect_rising_q[idx];
  assign rise_r   = rise_time_q[idx];
  assign width_r  = width_store_q[idx];
  assign is_cap   = in_range && (cmd_i.func == FuncCapture);

  // Pick the width case from the stored rise time and the falling value
  always_comb begin
    take_rise = is_cap && exp_r;
    normal_ok = (rise_r < cfg_i.rising_split) && (cmd_i.capture_value < cfg_i.period_top);
    wrap_ok   = (rise_r > cfg_i.rising_split) &&
                (cmd_i.capture_value < cfg_i.wrap_falling_limit);
    updated   = is_cap && !exp_r && (normal_ok || wrap_ok);
    if (normal_ok) begin
      new_width = cmd_i.capture_value - rise_r;
    end else begin
      new_width = cfg_i.period_top - rise_r + cmd_i.capture_value;
    end
  end

  // Build the result word
  always_comb begin
    res_o.out_channel = cmd_i.channel;
    if (!in_range) begin
      res_o.pulse_width      = '0;
      res_o.next_edge_rising = 1'b1;
      res_o.width_updated    = 1'b0;
    end else begin
      res_o.pulse_width      = updated ? new_width : width_r;
      res_o.next_edge_rising = is_cap ? !exp_r : exp_r;
      res_o.width_updated    = updated;
    end
  end

  // Toggle the expected edge on every in-range capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_rising_q <= '1;
    end else if (fire_i && is_cap) begin
      expect_rising_q[idx] <= !exp_r;
    end
  end

  // Store rise time and width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time_q[i]   <= '0;
        width_store_q[i] <= '0;
      end
    end else if (fire_i) begin
      if (take_rise) begin
        rise_time_q[idx] <= cmd_i.capture_value;
      end
      if (updated) begin
        width_store_q[idx] <= new_width;
      end
    end
  end

endmodule

>>> tb/sv/multichannel_pwm_pulse_capture_tb.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_pulse_capture_tb: self-checking bench for PWM pulse capture
// Streams capture and read words through the block under several register
// settings and compares every result word against a cycle-free channel model.
// Both stream sides idle and stall at random; the last phase runs at full rate.
// ----------------------------------------------------------------------------
module multichannel_pwm_pulse_capture_tb;
  import mpc_pkg::*;

  localparam int unsigned NumChan     = 8;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseWords  = 250;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [TimeW-1:0]   data;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  mpc_in_if  in_if ();
  mpc_out_if out_if ();
  mpc_cfg_if cfg_if ();

  multichannel_pwm_pulse_capture #(
    .CHANNELS(NumChan)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Words waiting to be sent, results waiting to arrive, register writes
  cmd_t       capture_words [$];
  res_t       width_results [$];
  reg_write_t reg_writes [$];

  // Channel model state and the live register set
  logic             chan_rising [NumChan];
  logic [TimeW-1:0] chan_rise   [NumChan];
  logic [TimeW-1:0] chan_width  [NumChan];
  cfg_t             cur_cfg;

  // Stimulus planning: settings of the phase and edge each channel will expect
  cfg_t plan_cfg;
  logic plan_rising [NumChan];
  int   queued;

  int in_idle_pct;
  int out_idle_pct;
  int in_gap;
  int out_stall;
  int mismatches;
  int stuck_cycles;

  always #6 clk_i = ~clk_i;

  // Advance the channel model by one word and return the result it produces
  function automatic res_t track_pulse(cmd_t w);
    res_t             r;
    logic [TimeW-1:0] rise;
    r.out_channel   = w.channel;
    r.width_updated = 1'b0;
    if (w.channel >= NumChan) begin
      r.pulse_width      = '0;
      r.next_edge_rising = 1'b1;
      return r;
    end
    if (w.func == FuncCapture) begin
      if (chan_rising[w.channel]) begin
        chan_rise[w.channel] = w.capture_value;
      end else begin
        rise = chan_rise[w.channel];
        if (rise < cur_cfg.rising_split && w.capture_value < cur_cfg.period_top) begin
          chan_width[w.channel] = w.capture_value - rise;
          r.width_updated = 1'b1;
        end else if (rise > cur_cfg.rising_split &&
                     w.capture_value < cur_cfg.wrap_falling_limit) begin
          // counter wrapped between the rising and the falling edge
          chan_width[w.channel] = cur_cfg.period_top - rise + w.capture_value;
          r.width_updated = 1'b1;
        end
      end
      chan_rising[w.channel] = !chan_rising[w.channel];
    end
    r.pulse_width      = chan_width[w.channel];
    r.next_edge_rising = chan_rising[w.channel];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, act_val);
    end
  endtask

  // Queue one word and keep track of which edge its channel expects next
  task automatic push_cmd(logic func, logic [ChanW-1:0] ch, logic [TimeW-1:0] val);
    cmd_t w;
    w.func          = func;
    w.channel       = ch;
    w.capture_value = val;
    capture_words.push_back(w);
    if (func == FuncCapture) begin
      plan_rising[ch] = !plan_rising[ch];
    end
    queued++;
  endtask

  // Rise times cluster around the split, with the full range mixed in
  function automatic logic [TimeW-1:0] pick_rise();
    logic [TimeW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = plan_cfg.rising_split + 16'($urandom_range(0, 2)) - 16'd1;
      1: v = 16'($urandom_range(0, plan_cfg.rising_split));
      2: v = 16'($urandom_range(plan_cfg.rising_split, 16'hFFFF));
      3: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Fall times cluster around the period top and the wrap limit
  function automatic logic [TimeW-1:0] pick_fall();
    logic [TimeW-1:0] v;
    case ($urandom_range(0, 6))
      0: v = plan_cfg.period_top + 16'($urandom_range(0, 3)) - 16'd2;
      1: v = plan_cfg.wrap_falling_limit + 16'($urandom_range(0, 3)) - 16'd2;
      2: v = 16'($urandom_range(0, plan_cfg.period_top));
      3: v = 16'($urandom_range(0, plan_cfg.wrap_falling_limit));
      4: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Hold until every queued word is sent and every result is back
  task automatic wait_drained();
    while (capture_words.size() != 0 || in_if.valid || width_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Input driver: present queued words, predict each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t w;
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.func          <= FuncCapture;
      in_if.channel       <= '0;
      in_if.capture_value <= '0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        width_results.push_back(track_pulse({in_if.func, in_if.channel, in_if.capture_value}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (capture_words.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 13);
          in_if.valid <= 1'b0;
        end else if (capture_words.size() != 0) begin
          w = capture_words.pop_front();
          in_if.valid         <= 1'b1;
          in_if.func          <= w.func;
          in_if.channel       <= w.channel;
          in_if.capture_value <= w.capture_value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted word, stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_res;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (width_results.size() == 0) begin
          note_mismatch("unexpected word, channel", '0, 32'(out_if.out_channel));
        end else begin
          exp_res = width_results.pop_front();
          if (out_if.out_channel !== exp_res.out_channel)
            note_mismatch("out_channel", 32'(exp_res.out_channel), 32'(out_if.out_channel));
          if (out_if.pulse_width !== exp_res.pulse_width)
            note_mismatch("pulse_width", 32'(exp_res.pulse_width), 32'(out_if.pulse_width));
          if (out_if.next_edge_rising !== exp_res.next_edge_rising)
            note_mismatch("next_edge_rising", 32'(exp_res.next_edge_rising),
                          32'(out_if.next_edge_rising));
          if (out_if.width_updated !== exp_res.width_updated)
            note_mismatch("width_updated", 32'(exp_res.width_updated),
                          32'(out_if.width_updated));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_stall = $urandom_range(0, 13);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Register write driver: apply each accepted write to the model
  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t rw;
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
      cfg_if.index <= RegPeriodTop;
      cfg_if.data  <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          RegPeriodTop:   cur_cfg.period_top         = cfg_if.data;
          RegRisingSplit: cur_cfg.rising_split       = cfg_if.data;
          RegWrapLimit:   cur_cfg.wrap_falling_limit = cfg_if.data;
          default: ;
        endcase
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (reg_writes.size() != 0) begin
          rw = reg_writes.pop_front();
          cfg_if.valid <= 1'b1;
          cfg_if.index <= rw.idx;
          cfg_if.data  <= rw.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed words, then one random phase per setting
  initial begin
    cfg_t phase_cfg [NumPhases];
    int   phase_in_pct  [NumPhases];
    int   phase_out_pct [NumPhases];
    logic [ChanW-1:0] ch;

    clk_i  = 1'b0;
    rst_ni = 1'b0;
    in_if.valid         = 1'b0;
    in_if.func          = FuncCapture;
    in_if.channel       = '0;
    in_if.capture_value = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = RegPeriodTop;
    cfg_if.data         = '0;
    mismatches   = 0;
    stuck_cycles = 0;
    queued       = 0;
    in_idle_pct  = 20;
    out_idle_pct = 20;
    cur_cfg  = '{PeriodTopRst, RisingSplitRst, WrapLimitRst};
    plan_cfg = cur_cfg;
    for (int i = 0; i < NumChan; i++) begin
      chan_rising[i] = 1'b1;
      chan_rise[i]   = '0;
      chan_width[i]  = '0;
      plan_rising[i] = 1'b1;
    end

    phase_cfg[0] = '{16'd0, 16'd0, 16'd0};
    phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_cfg[2] = '{16'hFFFF, 16'h8000, 16'hFFFF};
    phase_cfg[3] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    phase_cfg[4] = '{16'd5000, 16'd0, 16'hFFFF};
    phase_cfg[5] = '{16'd1000, 16'd600, 16'd400};
    phase_cfg[6] = '{PeriodTopRst, RisingSplitRst, WrapLimitRst};
    phase_in_pct  = '{25, 0, 50, 10, 35, 15, 0};
    phase_out_pct = '{10, 40, 0, 50, 20, 30, 0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words under the reset register values
    push_cmd(FuncRead, 3'd0, 16'd0);
    push_cmd(FuncRead, 3'd7, 16'd0);
    // plain pulse just inside the period top
    push_cmd(FuncCapture, 3'd0, 16'd0);
    push_cmd(FuncCapture, 3'd0, 16'd2498);
    // fall at the period top: width kept
    push_cmd(FuncCapture, 3'd0, 16'd0);
    push_cmd(FuncCapture, 3'd0, 16'd2499);
    // rise exactly on the split: width kept
    push_cmd(FuncCapture, 3'd1, 16'd1499);
    push_cmd(FuncCapture, 3'd1, 16'd10);
    // wrapped pulse just past the split
    push_cmd(FuncCapture, 3'd1, 16'd1500);
    push_cmd(FuncCapture, 3'd1, 16'd999);
    // wrapped pulse from the counter maximum
    push_cmd(FuncCapture, 3'd2, 16'hFFFF);
    push_cmd(FuncCapture, 3'd2, 16'd0);
    // plain pulse whose width goes negative and wraps to 16 bits
    push_cmd(FuncCapture, 3'd2, 16'd1498);
    push_cmd(FuncCapture, 3'd2, 16'd0);
    // both cases fail
    push_cmd(FuncCapture, 3'd3, 16'd2000);
    push_cmd(FuncCapture, 3'd3, 16'd1000);
    push_cmd(FuncCapture, 3'd3, 16'd1500);
    push_cmd(FuncCapture, 3'd3, 16'd1000);
    // read ignores the capture value
    push_cmd(FuncRead, 3'd7, 16'hFFFF);
    // zero-width pulse still updates
    push_cmd(FuncCapture, 3'd5, 16'd0);
    push_cmd(FuncCapture, 3'd5, 16'd0);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      in_idle_pct  = phase_in_pct[p];
      out_idle_pct = phase_out_pct[p];
      plan_cfg     = phase_cfg[p];
      reg_writes.push_back('{RegPeriodTop, plan_cfg.period_top});
      reg_writes.push_back('{RegRisingSplit, plan_cfg.rising_split});
      reg_writes.push_back('{RegWrapLimit, plan_cfg.wrap_falling_limit});
      if (p == 3) begin
        reg_writes.push_back('{RegUnused, 16'($urandom)});
      end
      while (reg_writes.size() != 0 || cfg_if.valid) @(negedge clk_i);

      // Mostly aligned rise/fall pairs, plus reads and stray edges
      queued = 0;
      while (queued < PhaseWords) begin
        ch = 3'($urandom_range(0, NumChan - 1));
        case ($urandom_range(0, 19))
          0, 1, 2: push_cmd(FuncRead, ch, 16'($urandom));
          3, 4:    push_cmd(FuncCapture, ch, 16'($urandom));
          default: begin
            if (!plan_rising[ch]) begin
              push_cmd(FuncCapture, ch, pick_fall());
            end
            push_cmd(FuncCapture, ch, pick_rise());
            push_cmd(FuncCapture, ch, pick_fall());
          end
        endcase
      end
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && width_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mpc_pkg.sv
design/mpc_if.sv
design/mpc_channel_bank.sv
design/multichannel_pwm_pulse_capture.sv
tb/sv/multichannel_pwm_pulse_capture_tb.sv
